[hw/rtl/frwe_pkg.sv]
package frwe_pkg;

  // field widths
  localparam int LEVEL_W  = 22;
  localparam int TIME_W   = 32;
  localparam int RATE_W   = 24;
  localparam int REMAIN_W = 26;
  localparam int STATUS_W = 2;

  // configuration register widths
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 22;
  localparam int CAP_W      = 22;
  localparam int MIN_INT_W  = 16;
  localparam int JUMP_W     = 20;
  localparam int READY_W    = 7;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TANK_CAPACITY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_INTERVAL  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REFUEL_JUMP   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_READY_COUNT   = 2'd3;

  // configuration reset values
  localparam logic [CAP_W-1:0]     CAP_RESET     = 22'd400000;
  localparam logic [MIN_INT_W-1:0] MIN_INT_RESET = 16'd1000;
  localparam logic [JUMP_W-1:0]    JUMP_RESET    = 20'd1000;
  localparam logic [READY_W-1:0]   READY_RESET   = 7'd5;

  // arithmetic constants
  localparam logic [RATE_W-1:0] RATE_MAX      = 24'hFFFFFF;
  localparam logic [RATE_W-1:0] MIN_AVG_RATE  = 24'd100;
  localparam logic [19:0]       RATE_SCALE    = 20'd1000000; // ul per ml times ms per s
  localparam logic [9:0]        MS_PER_S      = 10'd1000;

  // level status codes
  localparam logic [STATUS_W-1:0] STATUS_NORMAL   = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_LOW      = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_CRITICAL = 2'd2;

  // shared divider widths
  localparam int DVD_W = LEVEL_W + 20;
  localparam int DVS_W = TIME_W;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DVD_W-1:0] quotient;
  } div_rsp_t;

endpackage

[hw/rtl/frwe_div.sv]
module frwe_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  frwe_pkg::div_req_t req_i,
  output frwe_pkg::div_rsp_t rsp_o
);

  localparam int CNT_W = $clog2(frwe_pkg::DVD_W + 1);

  logic [frwe_pkg::DVD_W-1:0] dvd_q;
  logic [frwe_pkg::DVS_W-1:0] dvs_q;
  logic [frwe_pkg::DVS_W-1:0] rem_q;
  logic [CNT_W-1:0]           cnt_q;
  logic                       busy_q;
  logic                       done_q;

  logic [frwe_pkg::DVS_W:0]   rem_shift;
  logic [frwe_pkg::DVS_W:0]   rem_sub;
  logic                       fits;

  // one restoring step per cycle, no borrow means the divisor fits
  assign rem_shift = {rem_q, dvd_q[frwe_pkg::DVD_W-1]};
  assign rem_sub   = rem_shift - {1'b0, dvs_q};
  assign fits      = !rem_sub[frwe_pkg::DVS_W];

  // sequencing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CNT_W'(frwe_pkg::DVD_W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // dividend shifts out as the quotient shifts in
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dvd_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[frwe_pkg::DVD_W-2:0], fits};
      rem_q <= fits ? rem_sub[frwe_pkg::DVS_W-1:0] : rem_shift[frwe_pkg::DVS_W-1:0];
    end
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = dvd_q;

endmodule

[hw/rtl/fuel_rate_window_estimator_core.sv]
// Fuel rate window estimator.
// Input channel (in_valid_i/in_ready_o) takes one item: a tank level in ml and
// a millisecond timestamp. Output channel (out_valid_o/out_ready_i) gives one
// item per input: windowed average rate, remaining seconds, ready flag, level
// status and whether a rate sample was pushed. Configuration registers are
// written through cfg_we_i/cfg_idx_i/cfg_wdata_i; the user must write them
// only while the block is idle, as the block itself does not enforce this.
// An item passes decide, the rate division and push (only when a rate sample
// is taken), the average division, the remaining-time division and finish.
// A division is skipped for a zero rate, an empty window or an average at or
// below 100 respectively. The next item can be accepted in the cycle after
// the result is registered. The shared radix-2 divider (one quotient bit per
// cycle, 42 bits) is used in turn for the rate, the average and the remaining
// time. in_ready_o is high only while the sequencer is idle. A finished item
// sits in the output register; a new item may be accepted meanwhile, and its
// result waits until the receiver takes the previous one.
// Reset restores the default configuration, empties the window and clears the
// reference; the window memory itself is not cleared, the fill count masks it.
module fuel_rate_window_estimator_core #(
  parameter int WINDOW_DEPTH = 30
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [frwe_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [frwe_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [frwe_pkg::LEVEL_W-1:0]        fuel_level_ml_i,
  input  logic [frwe_pkg::TIME_W-1:0]         time_ms_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [frwe_pkg::RATE_W-1:0]         avg_rate_ulps_o,
  output logic [frwe_pkg::REMAIN_W-1:0]       remaining_seconds_o,
  output logic                                calc_ready_o,
  output logic [frwe_pkg::STATUS_W-1:0]       level_status_o,
  output logic                                sample_added_o
);

  localparam int PTR_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W = frwe_pkg::RATE_W + $clog2(WINDOW_DEPTH);
  localparam int CMP_W = frwe_pkg::READY_W + 1;

  // sequencer states
  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_DECIDE = 4'd1;
  localparam logic [3:0] ST_RMUL   = 4'd2;
  localparam logic [3:0] ST_RWAIT  = 4'd3;
  localparam logic [3:0] ST_PUSH   = 4'd4;
  localparam logic [3:0] ST_ACHK   = 4'd5;
  localparam logic [3:0] ST_AWAIT  = 4'd6;
  localparam logic [3:0] ST_MCHK   = 4'd7;
  localparam logic [3:0] ST_MWAIT  = 4'd8;
  localparam logic [3:0] ST_FINISH = 4'd9;

  logic [3:0] state_q, state_d;

  // configuration
  logic [frwe_pkg::CAP_W-1:0]     cap_q;
  logic [frwe_pkg::MIN_INT_W-1:0] min_int_q;
  logic [frwe_pkg::JUMP_W-1:0]    jump_q;
  logic [frwe_pkg::READY_W-1:0]   ready_cnt_q;

  // tracking state
  logic                          started_q;
  logic [frwe_pkg::LEVEL_W-1:0]  ref_level_q;
  logic [frwe_pkg::TIME_W-1:0]   ref_time_q;
  logic [PTR_W-1:0]              ptr_q;
  logic [CNT_W-1:0]              count_q;
  logic [SUM_W-1:0]              sum_q;

  // per-item working registers
  logic [frwe_pkg::LEVEL_W-1:0]  level_q;
  logic [frwe_pkg::TIME_W-1:0]   time_q;
  logic [frwe_pkg::TIME_W-1:0]   elapsed_q;
  logic [frwe_pkg::LEVEL_W-1:0]  drop_q;
  logic                          rate_zero_q;
  logic [frwe_pkg::STATUS_W-1:0] status_q;
  logic [frwe_pkg::RATE_W-1:0]   old_q;
  logic [SUM_W-1:0]              sum_less_q;
  logic [frwe_pkg::RATE_W-1:0]   avg_q;
  logic [frwe_pkg::REMAIN_W-1:0] remain_q;
  logic                          added_q;

  // output register
  logic                          out_valid_q;
  logic [frwe_pkg::RATE_W-1:0]   out_avg_q;
  logic [frwe_pkg::REMAIN_W-1:0] out_remain_q;
  logic                          out_ready_flag_q;
  logic [frwe_pkg::STATUS_W-1:0] out_status_q;
  logic                          out_added_q;

  // window store
  logic [frwe_pkg::RATE_W-1:0]   win_mem [WINDOW_DEPTH];

  frwe_pkg::div_req_t div_req;
  frwe_pkg::div_rsp_t div_rsp;

  logic                          in_acc;
  logic                          out_free;
  logic                          win_full;
  logic [frwe_pkg::LEVEL_W:0]    rise;
  logic [frwe_pkg::LEVEL_W:0]    fall;
  logic                          is_refuel;
  logic                          take_sample;
  logic [frwe_pkg::REMAIN_W-1:0] level_x10;
  logic [frwe_pkg::REMAIN_W-1:0] level_x4;
  logic [frwe_pkg::REMAIN_W-1:0] cap_ext;
  logic [frwe_pkg::RATE_W-1:0]   rate_new;
  logic                          mem_we;
  logic                          mem_re;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign win_full   = (count_q == CNT_W'(WINDOW_DEPTH));

  // refuel and drop tests against the reference
  assign rise        = {1'b0, level_q} - {1'b0, ref_level_q};
  assign fall        = {1'b0, ref_level_q} - {1'b0, level_q};
  assign is_refuel   = !rise[frwe_pkg::LEVEL_W] &&
                       (rise[frwe_pkg::LEVEL_W-1:0] > frwe_pkg::LEVEL_W'(jump_q));
  assign take_sample = (elapsed_q > frwe_pkg::TIME_W'(min_int_q));

  // level thresholds at 10 and 25 percent
  assign level_x10 = frwe_pkg::REMAIN_W'(level_q) * frwe_pkg::REMAIN_W'(10);
  assign level_x4  = {2'b00, level_q, 2'b00};
  assign cap_ext   = frwe_pkg::REMAIN_W'(cap_q);

  // saturated rate from the divider
  always_comb begin
    if (rate_zero_q) begin
      rate_new = '0;
    end else if (div_rsp.quotient[frwe_pkg::DVD_W-1:frwe_pkg::RATE_W] != '0) begin
      rate_new = frwe_pkg::RATE_MAX;
    end else begin
      rate_new = div_rsp.quotient[frwe_pkg::RATE_W-1:0];
    end
  end

  assign mem_re = (state_q == ST_DECIDE);
  assign mem_we = (state_q == ST_PUSH);

  // window memory, read before the push overwrites the oldest entry
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      win_mem[ptr_q] <= rate_new;
    end
    if (mem_re) begin
      old_q <= win_mem[ptr_q];
    end
  end

  // divider requests per state
  always_comb begin
    div_req = '0;
    case (state_q)
      ST_RMUL: begin
        div_req.start    = !rate_zero_q;
        div_req.dividend = frwe_pkg::DVD_W'(drop_q) * frwe_pkg::DVD_W'(frwe_pkg::RATE_SCALE);
        div_req.divisor  = elapsed_q;
      end
      ST_ACHK: begin
        div_req.start    = (count_q != '0);
        div_req.dividend = frwe_pkg::DVD_W'(sum_q);
        div_req.divisor  = frwe_pkg::DVS_W'(count_q);
      end
      ST_MCHK: begin
        div_req.start    = (avg_q > frwe_pkg::MIN_AVG_RATE);
        div_req.dividend = frwe_pkg::DVD_W'(level_q) * frwe_pkg::DVD_W'(frwe_pkg::MS_PER_S);
        div_req.divisor  = frwe_pkg::DVS_W'(avg_q);
      end
      default: begin
        div_req = '0;
      end
    endcase
  end

  frwe_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (started_q && !is_refuel && take_sample) begin
          state_d = ST_RMUL;
        end else begin
          state_d = ST_ACHK;
        end
      end
      ST_RMUL: begin
        state_d = rate_zero_q ? ST_PUSH : ST_RWAIT;
      end
      ST_RWAIT: begin
        if (div_rsp.done) begin
          state_d = ST_PUSH;
        end
      end
      ST_PUSH: begin
        state_d = ST_ACHK;
      end
      ST_ACHK: begin
        state_d = (count_q != '0) ? ST_AWAIT : ST_MCHK;
      end
      ST_AWAIT: begin
        if (div_rsp.done) begin
          state_d = ST_MCHK;
        end
      end
      ST_MCHK: begin
        state_d = (avg_q > frwe_pkg::MIN_AVG_RATE) ? ST_MWAIT : ST_FINISH;
      end
      ST_MWAIT: begin
        if (div_rsp.done) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control and tracking state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cap_q       <= frwe_pkg::CAP_RESET;
      min_int_q   <= frwe_pkg::MIN_INT_RESET;
      jump_q      <= frwe_pkg::JUMP_RESET;
      ready_cnt_q <= frwe_pkg::READY_RESET;
      started_q   <= 1'b0;
      ref_level_q <= '0;
      ref_time_q  <= '0;
      ptr_q       <= '0;
      count_q     <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;

      // register writes
      if (cfg_we_i) begin
        case (cfg_idx_i)
          frwe_pkg::REG_TANK_CAPACITY: cap_q <= cfg_wdata_i[frwe_pkg::CAP_W-1:0];
          frwe_pkg::REG_MIN_INTERVAL:  min_int_q <= cfg_wdata_i[frwe_pkg::MIN_INT_W-1:0];
          frwe_pkg::REG_REFUEL_JUMP:   jump_q <= cfg_wdata_i[frwe_pkg::JUMP_W-1:0];
          frwe_pkg::REG_READY_COUNT:   ready_cnt_q <= cfg_wdata_i[frwe_pkg::READY_W-1:0];
          default: begin
          end
        endcase
      end

      // first sample and refuel move the reference, refuel empties the window
      if (state_q == ST_DECIDE) begin
        if (!started_q) begin
          started_q   <= 1'b1;
          ref_level_q <= level_q;
          ref_time_q  <= time_q;
        end else if (is_refuel) begin
          ref_level_q <= level_q;
          ref_time_q  <= time_q;
          ptr_q       <= '0;
          count_q     <= '0;
          sum_q       <= '0;
        end
      end

      // push the new rate into the ring
      if (state_q == ST_PUSH) begin
        sum_q       <= sum_less_q + SUM_W'(rate_new);
        ptr_q       <= (ptr_q == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : ptr_q + PTR_W'(1);
        ref_level_q <= level_q;
        ref_time_q  <= time_q;
        if (!win_full) begin
          count_q <= count_q + CNT_W'(1);
        end
      end

      // output item handshake
      if (state_q == ST_FINISH && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // per-item datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      level_q   <= fuel_level_ml_i;
      time_q    <= time_ms_i;
      elapsed_q <= time_ms_i - ref_time_q;
      added_q   <= 1'b0;
      avg_q     <= '0;
      remain_q  <= '0;
    end
    if (state_q == ST_DECIDE) begin
      drop_q      <= fall[frwe_pkg::LEVEL_W-1:0];
      rate_zero_q <= fall[frwe_pkg::LEVEL_W] ||
                     (fall[frwe_pkg::LEVEL_W-1:0] <= frwe_pkg::LEVEL_W'(1));
      if (level_x10 < cap_ext) begin
        status_q <= frwe_pkg::STATUS_CRITICAL;
      end else if (level_x4 < cap_ext) begin
        status_q <= frwe_pkg::STATUS_LOW;
      end else begin
        status_q <= frwe_pkg::STATUS_NORMAL;
      end
    end
    if (state_q == ST_RMUL) begin
      sum_less_q <= sum_q - (win_full ? SUM_W'(old_q) : '0);
    end
    if (state_q == ST_PUSH) begin
      added_q <= 1'b1;
    end
    if (state_q == ST_AWAIT && div_rsp.done) begin
      avg_q <= div_rsp.quotient[frwe_pkg::RATE_W-1:0];
    end
    if (state_q == ST_MWAIT && div_rsp.done) begin
      remain_q <= div_rsp.quotient[frwe_pkg::REMAIN_W-1:0];
    end
    if (state_q == ST_FINISH && out_free) begin
      out_avg_q        <= avg_q;
      out_remain_q     <= remain_q;
      out_ready_flag_q <= (CMP_W'(count_q) >= CMP_W'(ready_cnt_q));
      out_status_q     <= status_q;
      out_added_q      <= added_q;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign avg_rate_ulps_o     = out_avg_q;
  assign remaining_seconds_o = out_remain_q;
  assign calc_ready_o        = out_ready_flag_q;
  assign level_status_o      = out_status_q;
  assign sample_added_o      = out_added_q;

  // fill count never passes the ring depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CMP_W'(count_q) <= CMP_W'(WINDOW_DEPTH))
    else $error("window fill count above depth");

  // ring pointer stays inside the ring
  a_ptr_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CMP_W'(ptr_q) < CMP_W'(WINDOW_DEPTH))
    else $error("window pointer out of range");

  // a divider result only arrives while the sequencer waits for one
  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == ST_RWAIT || state_q == ST_AWAIT || state_q == ST_MWAIT))
    else $error("divider done outside a wait state");

  // the shared divider is only started once the previous division is over
  a_div_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  // an accepted item is decided in the next cycle
  a_accept_decide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == ST_DECIDE))
    else $error("accepted item not decided");

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;

  localparam int WINDOW_DEPTH = 30;
  localparam int LEVEL_MAX    = (1 << frwe_pkg::LEVEL_W) - 1;
  localparam int PHASES       = 10;
  localparam int PHASE_ITEMS  = 143;
  localparam int LONG_HOLD    = 600;

  typedef struct packed {
    logic [frwe_pkg::LEVEL_W-1:0] level;
    logic [frwe_pkg::TIME_W-1:0]  stamp;
  } tank_sample_t;

  typedef struct packed {
    logic [frwe_pkg::RATE_W-1:0]   avg_rate;
    logic [frwe_pkg::REMAIN_W-1:0] remaining;
    logic                          ready;
    logic [frwe_pkg::STATUS_W-1:0] status;
    logic                          added;
  } fuel_estimate_t;

  logic                            clk_i;
  logic                            rst_ni              = 1'b0;
  logic                            cfg_we_i            = 1'b0;
  logic [frwe_pkg::CFG_IDX_W-1:0]  cfg_idx_i           = frwe_pkg::REG_TANK_CAPACITY;
  logic [frwe_pkg::CFG_DATA_W-1:0] cfg_wdata_i         = '0;
  logic                            in_valid_i          = 1'b0;
  logic                            in_ready_o;
  logic [frwe_pkg::LEVEL_W-1:0]    fuel_level_ml_i     = '0;
  logic [frwe_pkg::TIME_W-1:0]     time_ms_i           = '0;
  logic                            out_valid_o;
  logic                            out_ready_i         = 1'b0;
  logic [frwe_pkg::RATE_W-1:0]     avg_rate_ulps_o;
  logic [frwe_pkg::REMAIN_W-1:0]   remaining_seconds_o;
  logic                            calc_ready_o;
  logic [frwe_pkg::STATUS_W-1:0]   level_status_o;
  logic                            sample_added_o;

  fuel_rate_window_estimator_core #(
    .WINDOW_DEPTH(WINDOW_DEPTH)
  ) dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .fuel_level_ml_i    (fuel_level_ml_i),
    .time_ms_i          (time_ms_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .avg_rate_ulps_o    (avg_rate_ulps_o),
    .remaining_seconds_o(remaining_seconds_o),
    .calc_ready_o       (calc_ready_o),
    .level_status_o     (level_status_o),
    .sample_added_o     (sample_added_o)
  );

  // shadow copy of the configuration registers
  logic [frwe_pkg::CAP_W-1:0]     cap_cfg   = frwe_pkg::CAP_RESET;
  logic [frwe_pkg::MIN_INT_W-1:0] min_cfg   = frwe_pkg::MIN_INT_RESET;
  logic [frwe_pkg::JUMP_W-1:0]    jump_cfg  = frwe_pkg::JUMP_RESET;
  logic [frwe_pkg::READY_W-1:0]   ready_cfg = frwe_pkg::READY_RESET;

  // shadow copy of the tracking state and rate window
  logic                          tracking = 1'b0;
  logic [frwe_pkg::LEVEL_W-1:0]  ref_level = '0;
  logic [frwe_pkg::TIME_W-1:0]   ref_time = '0;
  logic [frwe_pkg::RATE_W-1:0]   win_rates [WINDOW_DEPTH];
  int unsigned                   win_ptr = 0;
  int unsigned                   win_count = 0;
  logic [31:0]                   win_sum = '0;

  tank_sample_t   queued_samples [$];
  fuel_estimate_t expected_estimates [$];

  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  int rate_samples = 0;
  int refuels = 0;
  int setting_writes = 0;
  bit idle_on = 1'b1;
  int hold_requests = 0;
  int hold_seen = 0;
  int send_gap = 0;
  int stall_left = 0;
  tank_sample_t next_sample;
  fuel_estimate_t want;

  // sample generator position
  int          trip_level;
  logic [31:0] trip_stamp;

  initial begin
    for (int i = 0; i < WINDOW_DEPTH; i++) win_rates[i] = '0;
  end

  // clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // one tank sample through the estimator: state update and result
  function automatic fuel_estimate_t estimate_fuel(
      input logic [frwe_pkg::LEVEL_W-1:0] level,
      input logic [frwe_pkg::TIME_W-1:0] now);
    fuel_estimate_t r;
    logic [frwe_pkg::TIME_W-1:0] elapsed;
    logic [63:0] drop64;
    logic [63:0] el64;
    logic [63:0] rate64;
    logic [63:0] lvl64;
    logic [63:0] rem64;
    logic [31:0] avg;
    r = '0;
    lvl64 = level;
    if (!tracking) begin
      ref_level = level;
      ref_time = now;
      tracking = 1'b1;
    end else begin
      elapsed = now - ref_time;
      if (level > ref_level && (level - ref_level) > jump_cfg) begin
        // refuel: empty the window and restart from here
        for (int i = 0; i < WINDOW_DEPTH; i++) win_rates[i] = '0;
        win_ptr = 0;
        win_count = 0;
        win_sum = '0;
        ref_level = level;
        ref_time = now;
        refuels++;
      end else if (elapsed > min_cfg) begin
        rate64 = '0;
        if (ref_level > level && (ref_level - level) > 1) begin
          drop64 = ref_level - level;
          el64 = elapsed;
          rate64 = drop64 * 64'd1000000 / el64;
          if (rate64 > frwe_pkg::RATE_MAX) rate64 = frwe_pkg::RATE_MAX;
        end
        win_sum = win_sum - win_rates[win_ptr] + rate64[frwe_pkg::RATE_W-1:0];
        win_rates[win_ptr] = rate64[frwe_pkg::RATE_W-1:0];
        win_ptr = (win_ptr + 1) % WINDOW_DEPTH;
        if (win_count < WINDOW_DEPTH) win_count++;
        ref_level = level;
        ref_time = now;
        r.added = 1'b1;
        rate_samples++;
      end
    end
    avg = (win_count > 0) ? win_sum / win_count : 32'd0;
    r.avg_rate = avg[frwe_pkg::RATE_W-1:0];
    if (avg > frwe_pkg::MIN_AVG_RATE) begin
      rem64 = lvl64 * 64'd1000 / {32'd0, avg};
      r.remaining = rem64[frwe_pkg::REMAIN_W-1:0];
    end
    r.ready = (win_count >= ready_cfg);
    if (lvl64 * 10 < cap_cfg) r.status = frwe_pkg::STATUS_CRITICAL;
    else if (lvl64 * 4 < cap_cfg) r.status = frwe_pkg::STATUS_LOW;
    else r.status = frwe_pkg::STATUS_NORMAL;
    return r;
  endfunction

  task automatic compare_field(input string field, input logic [31:0] exp_val,
                               input logic [31:0] got_val);
    if (exp_val !== got_val) begin
      errors++;
      $display("%0t ns: %s expected %0d, got %0d", $time, field, exp_val, got_val);
    end
  endtask

  // sender: offers queued samples, predicts each accepted one
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        expected_estimates.push_back(estimate_fuel(fuel_level_ml_i, time_ms_i));
        items_sent++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (queued_samples.size() == 0) begin
          in_valid_i <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
          send_gap = $urandom_range(0, 5);
          in_valid_i <= 1'b0;
        end else begin
          next_sample = queued_samples.pop_front();
          in_valid_i <= 1'b1;
          fuel_level_ml_i <= next_sample.level;
          time_ms_i <= next_sample.stamp;
        end
      end
    end
  end

  // receiver: checks each result item and stalls at random
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (expected_estimates.size() == 0) begin
          errors++;
          $display("%0t ns: result item with nothing expected, expected none, got avg %0d",
                   $time, avg_rate_ulps_o);
        end else begin
          want = expected_estimates.pop_front();
          compare_field("avg_rate_ulps", want.avg_rate, avg_rate_ulps_o);
          compare_field("remaining_seconds", want.remaining, remaining_seconds_o);
          compare_field("calc_ready", want.ready, calc_ready_o);
          compare_field("level_status", want.status, level_status_o);
          compare_field("sample_added", want.added, sample_added_o);
        end
      end
      if (hold_seen != hold_requests) begin
        hold_seen = hold_requests;
        stall_left = LONG_HOLD;
        out_ready_i <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 5);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic push_sample(input int level, input logic [31:0] stamp);
    tank_sample_t s;
    s.level = level[frwe_pkg::LEVEL_W-1:0];
    s.stamp = stamp;
    queued_samples.push_back(s);
  endtask

  task automatic write_setting(input logic [frwe_pkg::CFG_IDX_W-1:0] idx,
                               input logic [frwe_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      frwe_pkg::REG_TANK_CAPACITY: cap_cfg = val[frwe_pkg::CAP_W-1:0];
      frwe_pkg::REG_MIN_INTERVAL:  min_cfg = val[frwe_pkg::MIN_INT_W-1:0];
      frwe_pkg::REG_REFUEL_JUMP:   jump_cfg = val[frwe_pkg::JUMP_W-1:0];
      frwe_pkg::REG_READY_COUNT:   ready_cfg = val[frwe_pkg::READY_W-1:0];
      default: ;
    endcase
    setting_writes++;
  endtask

  // block is idle once nothing is queued, offered or outstanding
  task automatic wait_idle();
    while (queued_samples.size() != 0 || in_valid_i || expected_estimates.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_phase_config(input int p);
    int cap_v, min_v, jump_v, ready_v;
    case (p)
      1: begin cap_v = LEVEL_MAX; min_v = 0;     jump_v = 0;       ready_v = 0;   end
      2: begin cap_v = 0;         min_v = 65535; jump_v = 1048575; ready_v = 127; end
      3: begin cap_v = 400000;    min_v = 1;     jump_v = 500;     ready_v = 64;  end
      4: begin cap_v = 1000000;   min_v = 1000;  jump_v = 1000;    ready_v = 30;  end
      5: begin cap_v = 3000000;   min_v = 250;   jump_v = 20000;   ready_v = 1;   end
      default: begin
        cap_v = $urandom_range(0, LEVEL_MAX);
        min_v = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 3000);
        jump_v = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1048575)
                                             : $urandom_range(0, 20000);
        ready_v = $urandom_range(0, 127);
      end
    endcase
    write_setting(frwe_pkg::REG_TANK_CAPACITY, cap_v[frwe_pkg::CFG_DATA_W-1:0]);
    write_setting(frwe_pkg::REG_MIN_INTERVAL, min_v[frwe_pkg::CFG_DATA_W-1:0]);
    write_setting(frwe_pkg::REG_REFUEL_JUMP, jump_v[frwe_pkg::CFG_DATA_W-1:0]);
    write_setting(frwe_pkg::REG_READY_COUNT, ready_v[frwe_pkg::CFG_DATA_W-1:0]);
  endtask

  // a stretch of driving: mostly steady consumption with refuels and noise
  task automatic queue_trip(input int n_items);
    int pick;
    int amount;
    logic [31:0] dt;
    trip_level = $urandom_range(0, LEVEL_MAX);
    trip_stamp = $urandom();
    for (int i = 0; i < n_items; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        // noise: arbitrary level and timestamp
        trip_level = $urandom_range(0, LEVEL_MAX);
        trip_stamp = $urandom();
      end else begin
        if ($urandom_range(0, 9) == 0) dt = $urandom_range(0, min_cfg);
        else dt = min_cfg + 1 + $urandom_range(0, 2 * min_cfg + 100);
        trip_stamp = trip_stamp + dt;
        if (pick < 70) begin
          case ($urandom_range(0, 3))
            0: amount = $urandom_range(0, 2);
            1: amount = $urandom_range(0, 300);
            2: amount = $urandom_range(0, 5000);
            default: amount = $urandom_range(0, 60000);
          endcase
          trip_level = (amount > trip_level) ? 0 : trip_level - amount;
        end else begin
          if (pick < 85) amount = $urandom_range(0, jump_cfg);
          else if (pick < 92) amount = jump_cfg + 1 + $urandom_range(0, 100000);
          else amount = jump_cfg + $urandom_range(0, 1);
          trip_level = trip_level + amount;
          if (trip_level > LEVEL_MAX) trip_level = LEVEL_MAX;
        end
      end
      push_sample(trip_level, trip_stamp);
    end
  endtask

  // stimulus and verdict
  initial begin
    logic [31:0] t;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed items on the reset configuration
    t = 32'hFFFF_FE00;
    push_sample(200000, t);                // first sample only sets the reference
    t = t + 1001;
    push_sample(199000, t);                // timestamp wraps, 1 l drop
    push_sample(198999, t + 1000);         // interval not exceeded
    t = t + 1001;
    push_sample(198998, t);                // 2 ml drop, smallest nonzero rate
    t = t + 2000;
    push_sample(198997, t);                // 1 ml drop gives a zero rate
    t = t + 2000;
    push_sample(199997, t);                // rise equal to the refuel jump
    t = t + 10;
    push_sample(200998, t);                // rise just above the jump: refuel
    t = t + 1001;
    push_sample(0, t);                     // huge drop saturates the rate
    t = t + 5;
    push_sample(LEVEL_MAX, t);             // full tank, refuel again
    for (int k = 1; k <= 6; k++) begin
      t = t + 1500;
      push_sample(LEVEL_MAX - k * 20000, t);
    end
    // level status boundaries, no time elapsed
    push_sample(100000, t);
    push_sample(99999, t);
    push_sample(40000, t);
    push_sample(39999, t);
    push_sample(0, 32'hFFFF_FFFF);
    push_sample(LEVEL_MAX, 32'h0000_0000);
    wait_idle();

    // random phases over a range of settings
    for (int p = 1; p <= PHASES; p++) begin
      set_phase_config(p);
      idle_on = (p != PHASES);
      queue_trip(PHASE_ITEMS);
      if (p == 2) hold_requests++;
      wait_idle();
    end

    repeat (200) @(posedge clk_i);
    $display("run covered %0d items and %0d results over %0d register writes",
             items_sent, results_seen, setting_writes);
    $display("%0d rate samples pushed, %0d refuels seen", rate_samples, refuels);
    if (errors == 0 && expected_estimates.size() == 0)
      $display("[fuel_rate_window_estimator_core] OK");
    else
      $display("[fuel_rate_window_estimator_core] ERROR");
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("timeout with %0d results outstanding", expected_estimates.size());
    $display("[fuel_rate_window_estimator_core] ERROR");
    $finish;
  end

endmodule
